@@ src/gepc_pkg.sv @@
package gepc_pkg;

  localparam int MAX_DIM   = 64;
  localparam int MAX_MOVES = 64;
  localparam int DIM_W     = $clog2(MAX_DIM);
  localparam int DIMC_W    = DIM_W + 1;
  localparam int MOVE_W    = $clog2(MAX_MOVES + 1);
  localparam int CNT_W     = 30;
  localparam int ADDR_W    = 1 + 2 * DIM_W;

  localparam logic [CNT_W-1:0] EXIT_MOD = 30'd1000000007;

  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [DIMC_W-1:0] dimc_t;
  typedef logic [MOVE_W-1:0] move_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    PH_CENTER = 3'd0,
    PH_RIGHT  = 3'd1,
    PH_DOWN   = 3'd2,
    PH_LEFT   = 3'd3,
    PH_UP     = 3'd4
  } phase_t;

  typedef struct packed {
    logic   clear;
    logic   valid;
    phase_t phase;
    logic   outside;
    logic   first;
    logic   synth;
    dim_t   row;
    dim_t   col;
    logic   wbank;
  } acc_ctl_t;

  // Both operands are below the modulus, so one conditional subtract suffices.
  function automatic cnt_t add_mod(cnt_t a, cnt_t b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, EXIT_MOD}) begin
      s = s - {1'b0, EXIT_MOD};
    end
    return s[CNT_W-1:0];
  endfunction

endpackage

@@ src/gepc_ram.sv @@
module gepc_ram #(
  parameter int AW = 13,
  parameter int DW = 30
) (
  input  logic          clk,
  input  logic          wen,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/gepc_seq.sv @@
module gepc_seq import gepc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [6:0]          in_rows,
  input  logic [6:0]          in_cols,
  input  logic [6:0]          in_move_limit,
  input  logic [5:0]          in_start_row,
  input  logic [5:0]          in_start_col,
  output logic                busy,
  output logic                done,
  output logic                bad,
  output acc_ctl_t            ctl,
  output addr_t               raddr
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_GAP  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  dimc_t  rows_r, rows_nxt, cols_r, cols_nxt;
  move_t  moves_r, moves_nxt, move_r, move_nxt;
  dim_t   srow_r, srow_nxt, scol_r, scol_nxt;
  dim_t   row_r, row_nxt, col_r, col_nxt;
  phase_t phase_r, phase_nxt;
  logic   bank_r, bank_nxt;
  logic   bad_r, bad_nxt;

  dimc_t  rows_sat, cols_sat;
  move_t  moves_sat;
  logic   req_bad;
  logic   last_col, last_row;
  dim_t   nrow, ncol;
  logic   outside;

  assign rows_sat  = (int'(in_rows) > MAX_DIM) ? dimc_t'(MAX_DIM) : dimc_t'(in_rows);
  assign cols_sat  = (int'(in_cols) > MAX_DIM) ? dimc_t'(MAX_DIM) : dimc_t'(in_cols);
  assign moves_sat = (int'(in_move_limit) > MAX_MOVES) ? move_t'(MAX_MOVES)
                                                       : move_t'(in_move_limit);
  assign req_bad   = (dimc_t'(in_start_row) >= rows_sat) ||
                     (dimc_t'(in_start_col) >= cols_sat);

  assign last_col = (dimc_t'(col_r) + dimc_t'(1)) == cols_r;
  assign last_row = (dimc_t'(row_r) + dimc_t'(1)) == rows_r;

  always_comb begin
    nrow    = row_r;
    ncol    = col_r;
    outside = 1'b0;
    case (phase_r)
      PH_RIGHT: begin
        ncol    = dim_t'(col_r + 1'b1);
        outside = last_col;
      end
      PH_DOWN: begin
        nrow    = dim_t'(row_r + 1'b1);
        outside = last_row;
      end
      PH_LEFT: begin
        ncol    = dim_t'(col_r - 1'b1);
        outside = (col_r == '0);
      end
      PH_UP: begin
        nrow    = dim_t'(row_r - 1'b1);
        outside = (row_r == '0);
      end
      default: begin
        outside = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    rows_nxt  = rows_r;
    cols_nxt  = cols_r;
    moves_nxt = moves_r;
    move_nxt  = move_r;
    srow_nxt  = srow_r;
    scol_nxt  = scol_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    phase_nxt = phase_r;
    bank_nxt  = bank_r;
    bad_nxt   = bad_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          rows_nxt  = rows_sat;
          cols_nxt  = cols_sat;
          moves_nxt = moves_sat;
          srow_nxt  = dim_t'(in_start_row);
          scol_nxt  = dim_t'(in_start_col);
          move_nxt  = '0;
          row_nxt   = '0;
          col_nxt   = '0;
          phase_nxt = PH_CENTER;
          bank_nxt  = 1'b0;
          bad_nxt   = req_bad;
          if (req_bad || (moves_sat == '0)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        case (phase_r)
          PH_CENTER: phase_nxt = PH_RIGHT;
          PH_RIGHT:  phase_nxt = PH_DOWN;
          PH_DOWN:   phase_nxt = PH_LEFT;
          PH_LEFT:   phase_nxt = PH_UP;
          default: begin
            phase_nxt = PH_CENTER;
            if (last_col) begin
              col_nxt = '0;
              if (last_row) begin
                row_nxt   = '0;
                state_nxt = S_GAP;
              end else begin
                row_nxt = dim_t'(row_r + 1'b1);
              end
            end else begin
              col_nxt = dim_t'(col_r + 1'b1);
            end
          end
        endcase
      end
      S_GAP: begin
        // The last write of a move lands here, before the next move reads it back.
        if (move_t'(move_r + 1'b1) == moves_r) begin
          state_nxt = S_DONE;
        end else begin
          move_nxt  = move_t'(move_r + 1'b1);
          bank_nxt  = ~bank_r;
          state_nxt = S_RUN;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      move_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
      phase_r <= PH_CENTER;
      bank_r  <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      move_r  <= move_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      phase_r <= phase_nxt;
      bank_r  <= bank_nxt;
      bad_r   <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rows_r  <= rows_nxt;
    cols_r  <= cols_nxt;
    moves_r <= moves_nxt;
    srow_r  <= srow_nxt;
    scol_r  <= scol_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);
  assign bad  = bad_r;

  assign ctl.clear   = (state_r == S_IDLE) && start;
  assign ctl.valid   = (state_r == S_RUN);
  assign ctl.phase   = phase_r;
  assign ctl.outside = outside;
  assign ctl.first   = (move_r == '0);
  assign ctl.synth   = (nrow == srow_r) && (ncol == scol_r);
  assign ctl.row     = row_r;
  assign ctl.col     = col_r;
  assign ctl.wbank   = ~bank_r;

  assign raddr = {bank_r, nrow, ncol};

endmodule

@@ src/gepc_acc.sv @@
module gepc_acc import gepc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  acc_ctl_t ctl,
  input  cnt_t     rdata,
  output logic     wen,
  output addr_t    waddr,
  output cnt_t     wdata,
  output cnt_t     exit_total
);

  acc_ctl_t ctl_q_r;
  cnt_t     center_r, center_nxt;
  cnt_t     sum_r, sum_nxt;
  cnt_t     exit_r, exit_nxt;
  cnt_t     val;
  cnt_t     sum_add;

  // The first move has no stored counts: only the start cell holds one walk.
  assign val     = ctl_q_r.first ? cnt_t'(ctl_q_r.synth) : rdata;
  assign sum_add = add_mod(sum_r, val);

  always_comb begin
    center_nxt = center_r;
    sum_nxt    = sum_r;
    exit_nxt   = exit_r;
    if (ctl.clear) begin
      exit_nxt = '0;
    end else if (ctl_q_r.valid) begin
      case (ctl_q_r.phase)
        PH_CENTER: begin
          center_nxt = val;
          sum_nxt    = '0;
        end
        default: begin
          if (ctl_q_r.outside) begin
            exit_nxt = add_mod(exit_r, center_r);
          end else begin
            sum_nxt = sum_add;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_q_r <= '0;
    end else begin
      ctl_q_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exit_r <= '0;
    end else begin
      exit_r <= exit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    center_r <= center_nxt;
    sum_r    <= sum_nxt;
  end

  assign wen        = ctl_q_r.valid && (ctl_q_r.phase == PH_UP);
  assign waddr      = {ctl_q_r.wbank, ctl_q_r.row, ctl_q_r.col};
  assign wdata      = sum_nxt;
  assign exit_total = exit_r;

endmodule

@@ src/grid_exit_path_counter.sv @@
// Counts, modulo 1000000007, the four-direction walks of at most move_limit
// moves that start on a given cell of a rows by cols grid and step off it.
// A request is taken at a rising edge with start high and busy low; the
// fields are sampled at that edge. Rows and columns above 64 are clamped to
// 64, and so is a move limit above 64. Exactly one result follows each
// request: out_valid is high for one cycle with out_path_count and
// out_bad_request, and the receiver cannot hold it off.
// A start cell outside the grid gives a count of 0 and out_bad_request set;
// a move limit of 0 gives a count of 0. Both go from idle straight to the
// done state, which is registered onto out_valid. Otherwise the block runs
// M moves, for M the clamped move limit: each move sweeps every cell,
// and each cell takes five reads of the single read port of the count
// memory (the cell and its four neighbors), with a gap state between moves.
// The counts live in one 8192 by 30 memory split into two banks that
// alternate between current and next; it needs no clearing, since each move
// writes every cell the following move reads. busy falls in the cycle that
// shows out_valid, and a new request may be taken then. Synchronous reset
// returns the block to idle and drops any request in progress.
module grid_exit_path_counter import gepc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [6:0]  in_rows,
  input  logic [6:0]  in_cols,
  input  logic [6:0]  in_move_limit,
  input  logic [5:0]  in_start_row,
  input  logic [5:0]  in_start_col,
  output logic        out_valid,
  output logic [29:0] out_path_count,
  output logic        out_bad_request
);

  acc_ctl_t ctl;
  addr_t    raddr;
  addr_t    waddr;
  cnt_t     rdata;
  cnt_t     wdata;
  cnt_t     exit_total;
  logic     wen;
  logic     done;
  logic     bad;

  logic     out_valid_r, out_valid_nxt;
  cnt_t     out_path_count_r, out_path_count_nxt;
  logic     out_bad_request_r, out_bad_request_nxt;

  gepc_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_rows       (in_rows),
    .in_cols       (in_cols),
    .in_move_limit (in_move_limit),
    .in_start_row  (in_start_row),
    .in_start_col  (in_start_col),
    .busy          (busy),
    .done          (done),
    .bad           (bad),
    .ctl           (ctl),
    .raddr         (raddr)
  );

  gepc_acc u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rdata      (rdata),
    .wen        (wen),
    .waddr      (waddr),
    .wdata      (wdata),
    .exit_total (exit_total)
  );

  gepc_ram #(
    .AW (ADDR_W),
    .DW (CNT_W)
  ) u_ram (
    .clk   (clk),
    .wen   (wen),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    out_valid_nxt       = done;
    out_path_count_nxt  = out_path_count_r;
    out_bad_request_nxt = out_bad_request_r;
    if (done) begin
      out_path_count_nxt  = exit_total;
      out_bad_request_nxt = bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_path_count_r  <= out_path_count_nxt;
    out_bad_request_r <= out_bad_request_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_path_count  = out_path_count_r;
  assign out_bad_request = out_bad_request_r;

endmodule

@@ src/gepc_checker.sv @@
module gepc_checker import gepc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [29:0] out_path_count,
  input logic        out_bad_request
);

  // A rejected request always reports a count of zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_request |-> out_path_count == '0)
    else $error("bad request reported a nonzero count");

  // Every reported count is already reduced.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_path_count < EXIT_MOD)
    else $error("count not reduced");

  // A taken request keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken but block not busy");

  // The block leaves busy only by delivering its result.
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("busy dropped without a result");

  // Results of two requests can never be adjacent.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

endmodule

bind grid_exit_path_counter gepc_checker u_checker (.*);

@@ sim/grid_exit_path_counter_test.sv @@
module grid_exit_path_counter_test;
  import gepc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned PATH_MOD = 64'(EXIT_MOD);
  localparam int TAIL_CYCLES = 10;

  typedef struct {
    logic [29:0] path_count;
    logic        bad_request;
  } exit_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [6:0]  in_rows;
  logic [6:0]  in_cols;
  logic [6:0]  in_move_limit;
  logic [5:0]  in_start_row;
  logic [5:0]  in_start_col;
  logic        out_valid;
  logic [29:0] out_path_count;
  logic        out_bad_request;

  exit_result_t exit_results_due[$];
  int requests_sent = 0;
  int results_checked = 0;
  int off_grid_results = 0;
  int fail_count = 0;
  bit steady_feed = 1'b0;

  grid_exit_path_counter i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_rows         (in_rows),
    .in_cols         (in_cols),
    .in_move_limit   (in_move_limit),
    .in_start_row    (in_start_row),
    .in_start_col    (in_start_col),
    .out_valid       (out_valid),
    .out_path_count  (out_path_count),
    .out_bad_request (out_bad_request)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic exit_result_t predict_exit_count(logic [6:0] rows_raw,
                                                      logic [6:0] cols_raw,
                                                      logic [6:0] moves_raw,
                                                      logic [5:0] srow,
                                                      logic [5:0] scol);
    longint unsigned walks_here [MAX_DIM][MAX_DIM];
    longint unsigned walks_after [MAX_DIM][MAX_DIM];
    longint unsigned exit_sum;
    longint unsigned v;
    int rows, cols, moves;
    int m, r, c;
    exit_result_t res;
    rows = (rows_raw > MAX_DIM) ? MAX_DIM : int'(rows_raw);
    cols = (cols_raw > MAX_DIM) ? MAX_DIM : int'(cols_raw);
    moves = (moves_raw > MAX_MOVES) ? MAX_MOVES : int'(moves_raw);
    res.path_count = '0;
    res.bad_request = 1'b0;
    if (int'(srow) >= rows || int'(scol) >= cols) begin
      res.bad_request = 1'b1;
      return res;
    end
    walks_here = '{default: 0};
    walks_here[srow][scol] = 1;
    exit_sum = 0;
    for (m = 0; m < moves; m++) begin
      walks_after = '{default: 0};
      for (r = 0; r < rows; r++) begin
        for (c = 0; c < cols; c++) begin
          v = walks_here[r][c];
          if (v != 0) begin
            if (r == 0) exit_sum = (exit_sum + v) % PATH_MOD;
            else walks_after[r-1][c] = (walks_after[r-1][c] + v) % PATH_MOD;
            if (r == rows - 1) exit_sum = (exit_sum + v) % PATH_MOD;
            else walks_after[r+1][c] = (walks_after[r+1][c] + v) % PATH_MOD;
            if (c == 0) exit_sum = (exit_sum + v) % PATH_MOD;
            else walks_after[r][c-1] = (walks_after[r][c-1] + v) % PATH_MOD;
            if (c == cols - 1) exit_sum = (exit_sum + v) % PATH_MOD;
            else walks_after[r][c+1] = (walks_after[r][c+1] + v) % PATH_MOD;
          end
        end
      end
      walks_here = walks_after;
    end
    res.path_count = exit_sum[29:0];
    return res;
  endfunction

  task automatic send_request(input logic [6:0] rows, input logic [6:0] cols,
                              input logic [6:0] moves, input logic [5:0] srow,
                              input logic [5:0] scol);
    int gap;
    exit_result_t due;
    gap = steady_feed ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_rows <= rows;
    in_cols <= cols;
    in_move_limit <= moves;
    in_start_row <= srow;
    in_start_col <= scol;
    do @(posedge clk); while (busy);
    due = predict_exit_count(rows, cols, moves, srow, scol);
    exit_results_due.push_back(due);
    requests_sent++;
  endtask

  always @(posedge clk) begin
    exit_result_t due;
    if (rst_n && out_valid) begin
      if (exit_results_due.size() == 0) begin
        $error("result with no request outstanding: path_count %0d bad_request %0b",
               out_path_count, out_bad_request);
        fail_count++;
      end else begin
        due = exit_results_due.pop_front();
        results_checked++;
        if (out_bad_request) off_grid_results++;
        if (out_path_count !== due.path_count) begin
          $error("path_count: expected %0d, got %0d", due.path_count, out_path_count);
          fail_count++;
        end
        if (out_bad_request !== due.bad_request) begin
          $error("bad_request: expected %0b, got %0b", due.bad_request, out_bad_request);
          fail_count++;
        end
      end
    end
  end

  task automatic check_special_cases();
    send_request(7'd0, 7'd5, 7'd3, 6'd0, 6'd0);
    send_request(7'd5, 7'd0, 7'd3, 6'd0, 6'd0);
    send_request(7'd3, 7'd4, 7'd5, 6'd3, 6'd1);
    send_request(7'd4, 7'd3, 7'd5, 6'd1, 6'd3);
    send_request(7'd4, 7'd4, 7'd2, 6'd63, 6'd63);
    send_request(7'd5, 7'd5, 7'd0, 6'd2, 6'd2);
    send_request(7'd127, 7'd1, 7'd5, 6'd63, 6'd0);
    send_request(7'd65, 7'd2, 7'd4, 6'd10, 6'd1);
    send_request(7'd1, 7'd100, 7'd4, 6'd0, 6'd63);
    send_request(7'd1, 7'd1, 7'd127, 6'd0, 6'd0);
    send_request(7'd2, 7'd2, 7'd65, 6'd1, 6'd0);
  endtask

  task automatic check_extreme_sizes();
    send_request(7'd64, 7'd64, 7'd2, 6'd0, 6'd0);
    send_request(7'd64, 7'd64, 7'd1, 6'd63, 6'd63);
    send_request(7'd64, 7'd64, 7'd3, 6'd32, 6'd31);
    send_request(7'd1, 7'd1, 7'd64, 6'd0, 6'd0);
    send_request(7'd1, 7'd64, 7'd64, 6'd0, 6'd0);
    send_request(7'd64, 7'd1, 7'd64, 6'd63, 6'd0);
    send_request(7'd3, 7'd3, 7'd64, 6'd1, 6'd1);
    send_request(7'd8, 7'd8, 7'd64, 6'd3, 6'd4);
    send_request(7'd1, 7'd1, 7'd1, 6'd0, 6'd0);
  endtask

  task automatic check_random_requests(input int count);
    int i, kind;
    logic [6:0] rows, cols, moves;
    logic [5:0] srow, scol;
    for (i = 0; i < count; i++) begin
      if (i % 10 == 0) steady_feed = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        rows = 7'($urandom_range(1, 6));
        cols = 7'($urandom_range(1, 6));
        moves = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(65, 127))
                                            : 7'($urandom_range(0, 64));
        srow = 6'($urandom_range(0, rows - 1));
        scol = 6'($urandom_range(0, cols - 1));
      end else if (kind < 85) begin
        moves = 7'($urandom_range(0, 6));
        if ($urandom_range(0, 1) == 0) begin
          rows = 7'($urandom_range(64, 127));
          cols = 7'($urandom_range(1, 2));
          srow = 6'($urandom_range(0, 63));
          scol = 6'($urandom_range(0, cols - 1));
        end else begin
          rows = 7'($urandom_range(1, 2));
          cols = 7'($urandom_range(64, 127));
          srow = 6'($urandom_range(0, rows - 1));
          scol = 6'($urandom_range(0, 63));
        end
      end else begin
        rows = 7'($urandom_range(0, 7));
        cols = 7'($urandom_range(0, 7));
        moves = 7'($urandom_range(0, 127));
        srow = 6'($urandom_range(0, 63));
        scol = 6'($urandom_range(0, 63));
      end
      send_request(rows, cols, moves, srow, scol);
    end
    steady_feed = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_rows = '0;
    in_cols = '0;
    in_move_limit = '0;
    in_start_row = '0;
    in_start_col = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    check_special_cases();
    check_extreme_sizes();
    check_random_requests(100);
    start <= 1'b0;
    while (exit_results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests, including full 64 by 64 grids and clamped sizes;",
             requests_sent);
    $display("checked %0d results, %0d of them flagged as starting off the grid.",
             results_checked, off_grid_results);
    if (fail_count == 0) begin
      $display("grid_exit_path_counter_test: clean");
    end else begin
      $display("grid_exit_path_counter_test: errors");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Run stopped: results still outstanding after the time limit.");
    $display("grid_exit_path_counter_test: errors");
    $finish;
  end

endmodule

@@ grid_exit_path_counter.f @@
src/gepc_pkg.sv
src/gepc_ram.sv
src/gepc_seq.sv
src/gepc_acc.sv
src/grid_exit_path_counter.sv
src/gepc_checker.sv
sim/grid_exit_path_counter_test.sv
